// ===== hdl/i2cbs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// I2C bit sequencer package
// Command codes, pin action codes, sequence tables and the queue entry type
// shared by the front end and the execution unit.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

	// Depth of the queue between front end and execution unit.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		MODE_TICK  = 3'd0,
		MODE_START = 3'd1,
		MODE_STOP  = 3'd2,
		MODE_SEND  = 3'd3,
		MODE_RECV  = 3'd4,
		MODE_SACK  = 3'd5,
		MODE_RACK  = 3'd6,
		MODE_CHECK = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		OP_SCL0       = 3'd0,
		OP_SCL1       = 3'd1,
		OP_SDA0       = 3'd2,
		OP_SDA1       = 3'd3,
		OP_SDA_TX     = 3'd4,
		OP_SAMPLE_RX  = 3'd5,
		OP_SAMPLE_ACK = 3'd6
	} op_t;

	// One classified item as it waits in the queue.
	typedef struct packed {
		logic       is_cmd;
		mode_t      mode;
		logic [7:0] tx_load;
		logic       sda_level;
	} entry_t;

	// Number of pin actions of each command.
	function automatic logic [5:0] cmd_len(input mode_t m);
		logic [5:0] len;
		case (m)
			MODE_START: len = 6'd4;
			MODE_STOP:  len = 6'd3;
			MODE_SEND:  len = 6'd24;
			MODE_RECV:  len = 6'd25;
			MODE_SACK:  len = 6'd3;
			MODE_RACK:  len = 6'd4;
			MODE_CHECK: len = 6'd35;
			default:    len = 6'd0;
		endcase
		return len;
	endfunction

	function automatic op_t start_op(input logic [1:0] i);
		op_t op;
		case (i)
			2'd0:    op = OP_SDA1;
			2'd1:    op = OP_SCL1;
			2'd2:    op = OP_SDA0;
			default: op = OP_SCL0;
		endcase
		return op;
	endfunction

	function automatic op_t stop_op(input logic [1:0] i);
		op_t op;
		case (i)
			2'd0:    op = OP_SDA0;
			2'd1:    op = OP_SCL1;
			2'd2:    op = OP_SDA1;
			default: op = OP_SCL0;
		endcase
		return op;
	endfunction

	function automatic op_t rack_op(input logic [1:0] i);
		op_t op;
		case (i)
			2'd0:    op = OP_SDA1;
			2'd1:    op = OP_SCL1;
			2'd2:    op = OP_SAMPLE_ACK;
			default: op = OP_SCL0;
		endcase
		return op;
	endfunction

	// One bit slot of a byte: three actions, either transmit or receive.
	function automatic op_t byte_op(input logic [1:0] phase, input logic rx);
		op_t op;
		case (phase)
			2'd0:    op = rx ? OP_SCL1 : OP_SDA_TX;
			2'd1:    op = rx ? OP_SAMPLE_RX : OP_SCL1;
			default: op = OP_SCL0;
		endcase
		return op;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/i2cbs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// I2C bit sequencer front end
// Accepts input items, classifies them as command or tick, prepares the
// transmit register load value and queues them for the execution unit.
// ----------------------------------------------------------------------------
module i2cbs_front import i2cbs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	output logic            cmd_stall,
	input  wire logic [2:0] mode,
	input  wire logic [7:0] data_byte,
	input  wire logic       ack_value,
	input  wire logic       sda_level,
	output logic            q_valid,
	output entry_t          q_head,
	input  wire logic       q_pop
);

	entry_t             fifo_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	entry_t             item;
	mode_t              m;

	assign cmd_stall = (count_q == QCNT_W'(QDEPTH));
	assign push      = cmd_valid & ~cmd_stall;
	assign q_valid   = (count_q != '0);
	assign q_head    = fifo_q[rd_ptr_q];

	always_comb begin
		m            = mode_t'(mode);
		item.is_cmd  = (m != MODE_TICK);
		item.mode    = m;
		// Send ack carries its bit in the top position of the transmit register.
		item.tx_load = (m == MODE_SACK) ? {ack_value, 7'd0} : data_byte;
		item.sda_level = sda_level;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/i2cbs_exec.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// I2C bit sequencer execution unit
// Takes items from the queue, starts commands or runs one pin action per
// tick, and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module i2cbs_exec import i2cbs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  wire entry_t     q_head,
	output logic            q_pop,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic            scl_level,
	output logic            sda_release,
	output logic            busy_res,
	output logic            done_res,
	output logic [7:0]      rx_byte,
	output logic            ack_seen,
	output logic            rejected
);

	logic       scl_q, sda_q, ack_q;
	mode_t      cmd_q;
	logic [5:0] idx_q;
	logic [1:0] phase_q;
	logic [2:0] bitcnt_q;
	logic [7:0] tx_q, rx_q;
	logic       res_valid_q, done_q, rejected_q;

	logic       scl_d, sda_d, ack_d;
	mode_t      cmd_d;
	logic [5:0] idx_d, idx_inc;
	logic [1:0] phase_d;
	logic [2:0] bitcnt_d;
	logic [7:0] tx_d, rx_d;
	logic       done_d, rejected_d;
	logic       busy;
	logic       in_byte;
	op_t        op;

	assign busy  = (cmd_q != MODE_TICK);
	assign q_pop = q_valid & (~res_valid_q | ~res_stall);

	// Pin action for the current position of the active command.
	always_comb begin
		in_byte = 1'b0;
		op      = OP_SCL0;
		case (cmd_q)
			MODE_START: op = start_op(idx_q[1:0]);
			MODE_STOP:  op = stop_op(idx_q[1:0]);
			MODE_SEND, MODE_SACK: begin
				in_byte = 1'b1;
				op      = byte_op(phase_q, 1'b0);
			end
			MODE_RECV: begin
				if (idx_q == 6'd0) begin
					op = OP_SDA1;
				end else begin
					in_byte = 1'b1;
					op      = byte_op(phase_q, 1'b1);
				end
			end
			MODE_RACK:  op = rack_op(idx_q[1:0]);
			MODE_CHECK: begin
				// Start, address byte, ack slot and stop; segment offsets are
				// multiples of four so the low index bits select the step.
				if (idx_q < 6'd4) begin
					op = start_op(idx_q[1:0]);
				end else if (idx_q < 6'd28) begin
					in_byte = 1'b1;
					op      = byte_op(phase_q, 1'b0);
				end else if (idx_q < 6'd32) begin
					op = rack_op(idx_q[1:0]);
				end else begin
					op = stop_op(idx_q[1:0]);
				end
			end
			default: op = OP_SCL0;
		endcase
	end

	always_comb begin
		scl_d      = scl_q;
		sda_d      = sda_q;
		ack_d      = ack_q;
		cmd_d      = cmd_q;
		idx_d      = idx_q;
		phase_d    = phase_q;
		bitcnt_d   = bitcnt_q;
		tx_d       = tx_q;
		rx_d       = rx_q;
		done_d     = 1'b0;
		rejected_d = 1'b0;
		idx_inc    = idx_q + 6'd1;
		if (q_head.is_cmd) begin
			if (busy) begin
				rejected_d = 1'b1;
			end else begin
				cmd_d    = q_head.mode;
				idx_d    = '0;
				phase_d  = '0;
				bitcnt_d = '0;
				tx_d     = q_head.tx_load;
			end
		end else if (busy) begin
			case (op)
				OP_SCL0:      scl_d = 1'b0;
				OP_SCL1:      scl_d = 1'b1;
				OP_SDA0:      sda_d = 1'b0;
				OP_SDA1:      sda_d = 1'b1;
				OP_SDA_TX:    sda_d = tx_q[~bitcnt_q];
				OP_SAMPLE_RX: rx_d  = {rx_q[6:0], q_head.sda_level};
				default:      ack_d = q_head.sda_level;
			endcase
			if (in_byte) begin
				if (phase_q == 2'd2) begin
					phase_d  = '0;
					bitcnt_d = bitcnt_q + 3'd1;
				end else begin
					phase_d = phase_q + 2'd1;
				end
			end
			if (idx_inc == cmd_len(cmd_q)) begin
				cmd_d  = MODE_TICK;
				idx_d  = '0;
				done_d = 1'b1;
			end else begin
				idx_d = idx_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			ack_q       <= 1'b0;
			cmd_q       <= MODE_TICK;
			idx_q       <= '0;
			phase_q     <= '0;
			bitcnt_q    <= '0;
			tx_q        <= '0;
			rx_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= q_pop | (res_valid_q & res_stall);
			if (q_pop) begin
				scl_q    <= scl_d;
				sda_q    <= sda_d;
				ack_q    <= ack_d;
				cmd_q    <= cmd_d;
				idx_q    <= idx_d;
				phase_q  <= phase_d;
				bitcnt_q <= bitcnt_d;
				tx_q     <= tx_d;
				rx_q     <= rx_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			done_q     <= done_d;
			rejected_q <= rejected_d;
		end
	end

	// Sequencer state only moves when a result is produced, so it doubles as
	// the result payload.
	assign res_valid   = res_valid_q;
	assign scl_level   = scl_q;
	assign sda_release = sda_q;
	assign busy_res    = busy;
	assign done_res    = done_q;
	assign rx_byte     = rx_q;
	assign ack_seen    = ack_q;
	assign rejected    = rejected_q;

endmodule
`default_nettype wire

// ===== hdl/i2c_master_bit_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Open-drain SCL/SDA sequencer for start, stop, byte, ack and address check.
// ----------------------------------------------------------------------------
// Usage: each transfer on the cmd channel (cmd_valid high, cmd_stall low) is
// either a command (mode 1..7) or a tick (mode 0). A command is taken only
// while idle and is flagged as rejected otherwise; each tick then performs one
// pin action of the active command. Every input transfer produces exactly one
// result transfer on the res channel, in order, carrying the pin drive levels,
// busy/done flags, the receive register and the last sampled ack.
// Each input transfer is written into the queue and its result is registered
// from the queue head by the execution unit; one item is taken per cycle
// while the queue has room and the result is not held back by res_stall.
// A two-entry queue sits between the input classifier and the execution unit,
// and the result register holds a pending result while res_stall is high; the
// input side keeps accepting until the queue fills.
// Reset releases both pins, clears the receive register and ack latch and
// leaves the sequencer idle with no result pending.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer import i2cbs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	output logic            cmd_stall,
	input  wire logic [2:0] mode,
	input  wire logic [7:0] data_byte,
	input  wire logic       ack_value,
	input  wire logic       sda_level,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic            scl_level,
	output logic            sda_release,
	output logic            busy_res,
	output logic            done_res,
	output logic [7:0]      rx_byte,
	output logic            ack_seen,
	output logic            rejected
);

	logic   q_valid;
	logic   q_pop;
	entry_t q_head;

	i2cbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.mode      (mode),
		.data_byte (data_byte),
		.ack_value (ack_value),
		.sda_level (sda_level),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop)
	);

	i2cbs_exec u_exec (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.scl_level   (scl_level),
		.sda_release (sda_release),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.rx_byte     (rx_byte),
		.ack_seen    (ack_seen),
		.rejected    (rejected)
	);

endmodule
`default_nettype wire

// ===== hdl/i2cbs_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// I2C bit sequencer checker
// Port-level properties of the sequencer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module i2cbs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cmd_valid,
	input wire logic       cmd_stall,
	input wire logic       res_valid,
	input wire logic       res_stall,
	input wire logic       busy_res,
	input wire logic       done_res,
	input wire logic       rejected,
	input wire logic [7:0] rx_byte
);

	// A result that is held back stays offered and keeps its receive byte.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(rx_byte))
		else $error("result dropped or changed while stalled");

	// A rejected command can only happen while a command is still running.
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && rejected |-> busy_res)
		else $error("rejected transfer while idle");

	// Completion always returns the sequencer to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	// A single transfer cannot both finish a command and be rejected.
	a_done_rej: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(done_res && rejected))
		else $error("done and rejected together");

	// A result that appears after an empty spell comes from an earlier input
	// transfer that went through the queue and then the result register.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd_valid && !cmd_stall, 2))
		else $error("result without input transfer");

endmodule

bind i2c_master_bit_sequencer i2cbs_checker u_i2cbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.busy_res  (busy_res),
	.done_res  (done_res),
	.rejected  (rejected),
	.rx_byte   (rx_byte)
);
`default_nettype wire
